>>> rtl/core/twsj_pkg.sv
// Shared types, codes and constants for the time window stream join.
package twsj_pkg;

  localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] REQ_PULL       = 2'd2;
  localparam logic [1:0] REQ_CLEAR      = 2'd3;

  localparam logic [2:0] STAT_LOADED  = 3'd0;
  localparam logic [2:0] STAT_REFUSED = 3'd1;
  localparam logic [2:0] STAT_PAIR    = 3'd2;
  localparam logic [2:0] STAT_DONE    = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  localparam logic [62:0] DEFAULT_HALF_WIDTH = 63'd1000;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [63:0] record_time;
    logic [63:0]        record_value;
  } req_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] left_time;
    logic [63:0]        left_payload;
    logic signed [63:0] right_time;
    logic [63:0]        right_payload;
  } rsp_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_LOOP,
    S_L_WAIT,
    S_SRCH,
    S_S_WAIT,
    S_R_CHK,
    S_R_WAIT,
    S_RESP
  } state_t;

endpackage

>>> rtl/core/twsj_ram.sv
// Generic simple dual port RAM with registered read.
module twsj_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/twsj_engine.sv
// Join sequencer: record stores, sorted insert, window search and pair scan.
module twsj_engine #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  twsj_pkg::req_word_t req_word,
  input  logic [62:0]       half_width,
  input  logic              res_ready,
  output logic              busy,
  output logic              res_valid,
  output twsj_pkg::rsp_word_t res_word
);
  import twsj_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STORE_DEPTH);

  state_t state, state_next;
  req_word_t req, req_next;
  rsp_word_t res, res_next;
  logic [CW-1:0] lfill, lfill_next, rfill, rfill_next;
  logic [CW-1:0] lc, lc_next, rc, rc_next, pos, pos_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid_full;
  logic [AW-1:0] mid, mid_next;
  logic started, started_next, finished, finished_next, adv, adv_next;
  logic [63:0] ltime, ltime_next, lpay, lpay_next, bound, bound_next;
  logic [63:0] lkey, rkey_rd;
  logic [64:0] upper;

  logic          l_we, l_re, r_we, r_re;
  logic [AW-1:0] l_waddr, l_raddr, r_waddr, r_raddr;
  logic [127:0]  l_wdata, r_wdata, l_rdata, r_rdata;

  twsj_ram #(.WIDTH(128), .DEPTH(STORE_DEPTH)) u_left (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  twsj_ram #(.WIDTH(128), .DEPTH(STORE_DEPTH)) u_right (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
  );

  assign lkey     = ltime ^ SIGN_BIT;
  assign rkey_rd  = r_rdata[127:64] ^ SIGN_BIT;
  assign upper    = {1'b0, lkey} + {2'b00, half_width};
  assign mid_full = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lfill    <= '0;
      rfill    <= '0;
      lc       <= '0;
      rc       <= '0;
      started  <= 1'b0;
      finished <= 1'b0;
      adv      <= 1'b0;
    end else begin
      state    <= state_next;
      lfill    <= lfill_next;
      rfill    <= rfill_next;
      lc       <= lc_next;
      rc       <= rc_next;
      started  <= started_next;
      finished <= finished_next;
      adv      <= adv_next;
    end
    req   <= req_next;
    res   <= res_next;
    pos   <= pos_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    ltime <= ltime_next;
    lpay  <= lpay_next;
    bound <= bound_next;
  end

  always_comb begin
    state_next    = state;
    req_next      = req;
    res_next      = res;
    lfill_next    = lfill;
    rfill_next    = rfill;
    lc_next       = lc;
    rc_next       = rc;
    pos_next      = pos;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    started_next  = started;
    finished_next = finished;
    adv_next      = adv;
    ltime_next    = ltime;
    lpay_next     = lpay;
    bound_next    = bound;
    l_we = 1'b0; l_re = 1'b0; r_we = 1'b0; r_re = 1'b0;
    l_waddr = '0; l_raddr = '0; r_waddr = '0; r_raddr = '0;
    l_wdata = '0; r_wdata = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = req_word;
          res_next = '0;
          state_next = S_RESP;
          unique case (req_word.req_type)
            REQ_LOAD_LEFT: begin
              if (started || lfill == FULL) begin
                res_next.status = STAT_REFUSED;
              end else begin
                l_we = 1'b1;
                l_waddr = lfill[AW-1:0];
                l_wdata = {req_word.record_time, req_word.record_value};
                lfill_next = lfill + 1'b1;
                res_next.status = STAT_LOADED;
              end
            end
            REQ_LOAD_RIGHT: begin
              if (started || rfill == FULL) begin
                res_next.status = STAT_REFUSED;
              end else begin
                pos_next = rfill;
                state_next = S_INS_RD;
              end
            end
            REQ_CLEAR: begin
              lc_next = '0;
              rc_next = '0;
              started_next = 1'b0;
              finished_next = 1'b0;
              adv_next = 1'b0;
              res_next.status = STAT_CLEARED;
            end
            default: begin
              if (finished) begin
                res_next.status = STAT_DONE;
              end else begin
                if (!started) begin
                  started_next = 1'b1;
                  lc_next = '0;
                  rc_next = '0;
                end
                state_next = S_LOOP;
              end
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (pos == '0) begin
          r_we = 1'b1;
          r_waddr = '0;
          r_wdata = {req.record_time, req.record_value};
          rfill_next = rfill + 1'b1;
          res_next.status = STAT_LOADED;
          state_next = S_RESP;
        end else begin
          r_re = 1'b1;
          r_raddr = AW'(pos - 1'b1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        r_we = 1'b1;
        r_waddr = pos[AW-1:0];
        if (rkey_rd > (req.record_time ^ SIGN_BIT)) begin
          r_wdata = r_rdata;
          pos_next = pos - 1'b1;
          state_next = S_INS_RD;
        end else begin
          r_wdata = {req.record_time, req.record_value};
          rfill_next = rfill + 1'b1;
          res_next.status = STAT_LOADED;
          state_next = S_RESP;
        end
      end
      S_LOOP: begin
        if (lc >= lfill) begin
          finished_next = 1'b1;
          res_next.status = STAT_DONE;
          state_next = S_RESP;
        end else begin
          l_re = 1'b1;
          l_raddr = lc[AW-1:0];
          state_next = S_L_WAIT;
        end
      end
      S_L_WAIT: begin
        ltime_next = l_rdata[127:64];
        lpay_next = l_rdata[63:0];
        state_next = S_R_CHK;
        if (rc == '0 || adv) begin
          adv_next = 1'b0;
          if ((l_rdata[127:64] ^ SIGN_BIT) < {1'b0, half_width}) begin
            rc_next = '0;
          end else begin
            bound_next = (l_rdata[127:64] ^ SIGN_BIT) - {1'b0, half_width};
            lo_next = '0;
            hi_next = rfill;
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo < hi) begin
          mid_next = mid_full[AW-1:0];
          r_re = 1'b1;
          r_raddr = mid_full[AW-1:0];
          state_next = S_S_WAIT;
        end else begin
          rc_next = lo;
          state_next = S_R_CHK;
        end
      end
      S_S_WAIT: begin
        if (rkey_rd < bound) begin
          lo_next = CW'(mid) + 1'b1;
        end else begin
          hi_next = CW'(mid);
        end
        state_next = S_SRCH;
      end
      S_R_CHK: begin
        if (rc < rfill) begin
          r_re = 1'b1;
          r_raddr = rc[AW-1:0];
          state_next = S_R_WAIT;
        end else begin
          lc_next = lc + 1'b1;
          adv_next = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_R_WAIT: begin
        if ({1'b0, rkey_rd} > upper) begin
          lc_next = lc + 1'b1;
          adv_next = 1'b1;
          state_next = S_LOOP;
        end else begin
          res_next.status = STAT_PAIR;
          res_next.left_time = ltime;
          res_next.left_payload = lpay;
          res_next.right_time = r_rdata[127:64];
          res_next.right_payload = r_rdata[63:0];
          rc_next = rc + 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res_word  = res;

endmodule

>>> rtl/core/time_window_stream_join.sv
// Top level of the time window stream join: config register and result register.
//
// Requests arrive on req_valid/req_stall/req_word, one word at a time; each
// yields exactly one response word on rsp_valid/rsp_stall/rsp_word.
// cfg_we/cfg_data set the window half width (zero selects 1000).
// Work per request:
//   load left, clear, refused load or pull after the join is done: answered straight from idle
//   load right: each stored entry with a larger time is shifted up to keep
//               time order; it stops at an entry with a smaller or equal time
//   pull: visits left records and checks right records in time order, with
//         a check when a right scan runs off the end and a final check when
//         no left record remains, plus a binary search when the join moves
//         to a new left record
// req_stall stays high while a request is in work. A finished response is
// parked in the output register as the engine goes idle, so a stalled receiver
// only holds up the request after it. Synchronous reset empties both stores,
// clears the join state and sets the half width to 1000; no clearing pass
// is needed.
module time_window_stream_join #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  twsj_pkg::req_word_t req_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output twsj_pkg::rsp_word_t rsp_word,
  input  logic                cfg_we,
  input  logic [62:0]         cfg_data
);
  import twsj_pkg::*;

  logic        busy, start, res_valid, res_ready;
  rsp_word_t   res_word;
  logic [62:0] half_width;

  assign req_stall = busy;
  assign start     = req_valid && !busy;
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= DEFAULT_HALF_WIDTH;
    end else if (cfg_we) begin
      half_width <= (cfg_data == '0) ? DEFAULT_HALF_WIDTH : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      rsp_word <= res_word;
    end
  end

  twsj_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req_word(req_word),
    .half_width(half_width),
    .res_ready(res_ready),
    .busy(busy),
    .res_valid(res_valid),
    .res_word(res_word)
  );

endmodule
